// File: rtl/core/dfr_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
`default_nettype none

package dfr_pkg;

  // Header layout: 4 magic bytes then 4 length bytes, little-endian
  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned HDR_IDX_W = 3;
  localparam int unsigned CNT_W     = 16;

  // Largest accepted total packet length, header included
  localparam logic [31:0] MAX_PACKET_BYTES = 32'd61440;
  localparam logic [31:0] MIN_PACKET_BYTES = 32'd9;

  // Register map
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_MAGIC_WORD = 1'b0;

  // One result word
  typedef struct packed {
    logic [7:0] packet_byte;
    logic       first_flag;
    logic       last_flag;
    logic       bad_header;
  } dfr_res_t;

  // Push side of the output buffer
  typedef struct packed {
    logic     valid;
    dfr_res_t res;
  } dfr_push_t;

endpackage

`default_nettype wire

// File: rtl/core/length_prefixed_frame_deframer.sv
// Top level of the length-prefixed frame deframer.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    in_data_byte
//   out      source     out_valid / out_ready  out_packet_byte, out_first_flag,
//                                              out_last_flag, out_bad_header
//   cfg      APB slave  psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// With in_ready and out_ready high, words are taken and results leave one per cycle.
// Body and error results reach out_valid in the cycle after their word is taken.
// After the eighth word of a good header, in_ready drops while the header replays;
// its first word goes through rep_active_r and the output buffer to out_valid.
// The two-entry output buffer keeps in_ready high under out_ready low until it is full.
// Reset (rst_n, synchronous) clears the count, the body flag and the magic word.
`default_nettype none

module length_prefixed_frame_deframer
  import dfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_data_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [7:0]        out_packet_byte,
  output logic                   out_first_flag,
  output logic                   out_last_flag,
  output logic                   out_bad_header,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic [31:0] magic_word;
  logic        push_ok;
  dfr_push_t   push;

  dfr_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .magic_word (magic_word)
  );

  dfr_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .magic_word   (magic_word),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .push_ok      (push_ok),
    .push         (push)
  );

  dfr_outbuf u_outbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .push_ok         (push_ok),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packet_byte (out_packet_byte),
    .out_first_flag  (out_first_flag),
    .out_last_flag   (out_last_flag),
    .out_bad_header  (out_bad_header)
  );

endmodule

`default_nettype wire

// File: rtl/core/dfr_regs.sv
// APB-style configuration register block holding the magic word.
`default_nettype none

module dfr_regs
  import dfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output logic      [31:0]       magic_word
);

  logic [31:0]          magic_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  // word-aligned register index
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_MAGIC_WORD);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0;
    end else if (wr_en) begin
      magic_r <= pwdata;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_MAGIC_WORD) begin
      prdata = magic_r;
    end
  end

  assign magic_word = magic_r;

endmodule

`default_nettype wire

// File: rtl/core/dfr_parse.sv
// Header hunt, header check, header replay and body pass-through.
`default_nettype none

module dfr_parse
  import dfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] magic_word,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        push_ok,
  output dfr_push_t        push
);

  logic [7:0]           hdr_r [HDR_BYTES];
  logic [CNT_W-1:0]     byte_count_r, byte_count_nxt;
  logic [CNT_W-1:0]     packet_length_r, packet_length_nxt;
  logic                 in_body_r, in_body_nxt;
  logic                 rep_active_r, rep_active_nxt;
  logic [HDR_IDX_W-1:0] rep_idx_r, rep_idx_nxt;

  logic                 acc;
  logic [CNT_W-1:0]     cnt_inc;
  logic [31:0]          hdr_magic;
  logic [31:0]          hdr_len;
  logic                 hdr_bad;
  logic                 hdr_done;

  // input is held while the header is replayed or the buffer is full
  assign in_ready = !rep_active_r && push_ok;
  assign acc      = in_valid && in_ready;
  assign cnt_inc  = byte_count_r + CNT_W'(1);

  // header fields; byte 7 is the word arriving now
  assign hdr_magic = {hdr_r[3], hdr_r[2], hdr_r[1], hdr_r[0]};
  assign hdr_len   = {in_data_byte, hdr_r[6], hdr_r[5], hdr_r[4]};
  assign hdr_done  = (byte_count_r[HDR_IDX_W-1:0] == HDR_IDX_W'(HDR_BYTES - 1));
  assign hdr_bad   = (hdr_magic != magic_word) || (hdr_len < MIN_PACKET_BYTES) ||
                     (hdr_len > MAX_PACKET_BYTES);

  // next state and result push
  always_comb begin
    byte_count_nxt    = byte_count_r;
    packet_length_nxt = packet_length_r;
    in_body_nxt       = in_body_r;
    rep_active_nxt    = rep_active_r;
    rep_idx_nxt       = rep_idx_r;
    push              = '0;

    if (rep_active_r) begin
      // replay the stored header, one word per cycle while the buffer has room
      if (push_ok) begin
        push.valid           = 1'b1;
        push.res.packet_byte = hdr_r[rep_idx_r];
        push.res.first_flag  = (rep_idx_r == '0);
        rep_idx_nxt          = rep_idx_r + HDR_IDX_W'(1);
        if (rep_idx_r == HDR_IDX_W'(HDR_BYTES - 1)) begin
          rep_active_nxt = 1'b0;
        end
      end
    end else if (acc) begin
      if (in_body_r) begin
        // body word passes straight through
        push.valid           = 1'b1;
        push.res.packet_byte = in_data_byte;
        push.res.last_flag   = (cnt_inc >= packet_length_r);
        if (cnt_inc >= packet_length_r) begin
          in_body_nxt    = 1'b0;
          byte_count_nxt = '0;
        end else begin
          byte_count_nxt = cnt_inc;
        end
      end else if (!hdr_done) begin
        byte_count_nxt = cnt_inc;
      end else if (hdr_bad) begin
        push.valid          = 1'b1;
        push.res.bad_header = 1'b1;
        byte_count_nxt      = '0;
      end else begin
        packet_length_nxt = hdr_len[CNT_W-1:0];
        in_body_nxt       = 1'b1;
        byte_count_nxt    = CNT_W'(HDR_BYTES);
        rep_active_nxt    = 1'b1;
        rep_idx_nxt       = '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= '0;
      packet_length_r <= '0;
      in_body_r       <= 1'b0;
      rep_active_r    <= 1'b0;
      rep_idx_r       <= '0;
    end else begin
      byte_count_r    <= byte_count_nxt;
      packet_length_r <= packet_length_nxt;
      in_body_r       <= in_body_nxt;
      rep_active_r    <= rep_active_nxt;
      rep_idx_r       <= rep_idx_nxt;
    end
  end

  // header store, written while hunting
  always_ff @(posedge clk) begin
    if (acc && !in_body_r) begin
      hdr_r[byte_count_r[HDR_IDX_W-1:0]] <= in_data_byte;
    end
  end

  // replay only ever runs inside an accepted packet
  a_replay_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    rep_active_r |-> in_body_r)
    else $error("header replay outside packet");

  // while hunting the count stays inside the header
  a_hunt_count: assert property (@(posedge clk) disable iff (!rst_n)
    !in_body_r |-> (byte_count_r < CNT_W'(HDR_BYTES)))
    else $error("hunt count beyond header");

  // an open packet has a legal length and is not yet complete
  a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (packet_length_r >= CNT_W'(MIN_PACKET_BYTES)) &&
                  (byte_count_r < packet_length_r))
    else $error("body count out of range");

  // a pushed first-flagged word comes only from the header replay, never as a bad header
  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && push.res.first_flag) |-> (rep_active_r && !push.res.bad_header))
    else $error("first flag outside replay");

endmodule

`default_nettype wire

// File: rtl/core/dfr_outbuf.sv
// Two-entry output buffer that parts the result channel from the parser.
`default_nettype none

module dfr_outbuf
  import dfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dfr_push_t  push,
  output logic            push_ok,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_packet_byte,
  output logic            out_first_flag,
  output logic            out_last_flag,
  output logic            out_bad_header
);

  dfr_res_t   ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;
  dfr_res_t   head;

  assign push_ok   = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign head      = ent_r[rd_ptr_r];

  assign out_packet_byte = head.packet_byte;
  assign out_first_flag  = head.first_flag;
  assign out_last_flag   = head.last_flag;
  assign out_bad_header  = head.bad_header;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push.valid} - {1'b0, pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      ent_r[wr_ptr_r] <= push.res;
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the length-prefixed frame deframer.
`default_nettype none

module tb_top;
  import dfr_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_data_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_packet_byte;
  logic              out_first_flag;
  logic              out_last_flag;
  logic              out_bad_header;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  length_prefixed_frame_deframer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packet_byte (out_packet_byte),
    .out_first_flag  (out_first_flag),
    .out_last_flag   (out_last_flag),
    .out_bad_header  (out_bad_header),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Clock: period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stream words waiting to be sent, and results the deframer owes us
  logic [7:0] rx_bytes_q[$];
  dfr_res_t   deframed_q[$];
  int         mismatch_cnt = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;

  // Deframer state as the testbench sees it
  logic [7:0]  hdr_bytes[HDR_BYTES];
  logic [15:0] frame_cnt = '0;
  logic [15:0] frame_len = '0;
  logic        in_payload = 1'b0;
  logic [31:0] cur_magic = '0;

  // Advance the deframer state by one received word, queue what it emits
  function automatic void deframe_byte(logic [7:0] b);
    dfr_res_t    r;
    logic [31:0] hdr_magic;
    logic [31:0] hdr_len;
    r = '0;
    if (in_payload) begin
      frame_cnt = frame_cnt + 16'd1;
      r.packet_byte = b;
      r.last_flag = (frame_cnt >= frame_len);
      deframed_q.push_back(r);
      if (r.last_flag) begin
        in_payload = 1'b0;
        frame_cnt = '0;
      end
      return;
    end
    hdr_bytes[frame_cnt[HDR_IDX_W-1:0]] = b;
    frame_cnt = frame_cnt + 16'd1;
    if (frame_cnt < HDR_BYTES) return;
    hdr_magic = {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]};
    hdr_len   = {hdr_bytes[7], hdr_bytes[6], hdr_bytes[5], hdr_bytes[4]};
    if (hdr_magic != cur_magic || hdr_len < MIN_PACKET_BYTES ||
        hdr_len > MAX_PACKET_BYTES) begin
      frame_cnt = '0;
      r.bad_header = 1'b1;
      deframed_q.push_back(r);
      return;
    end
    // good header: replay the 8 stored words, first one flagged
    frame_len = hdr_len[15:0];
    in_payload = 1'b1;
    frame_cnt = 16'(HDR_BYTES);
    for (int k = 0; k < HDR_BYTES; k++) begin
      r = '0;
      r.packet_byte = hdr_bytes[k];
      r.first_flag = (k == 0);
      deframed_q.push_back(r);
    end
  endfunction

  // Driver: feeds words from the pending queue, with random idle cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) deframe_byte(in_data_byte);
      if (!in_valid || in_ready) begin
        if (rx_bytes_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          in_data_byte <= rx_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: each accepted result against the oldest expectation
  always @(posedge clk) begin
    dfr_res_t got;
    dfr_res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_packet_byte, out_first_flag, out_last_flag, out_bad_header};
      if (deframed_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: byte=%h first=%b last=%b bad=%b",
                   got.packet_byte, got.first_flag, got.last_flag, got.bad_header);
      end else begin
        want = deframed_q.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp byte/first/last/bad=%h/%b/%b/%b, got %h/%b/%b/%b",
                     want.packet_byte, want.first_flag, want.last_flag, want.bad_header,
                     got.packet_byte, got.first_flag, got.last_flag, got.bad_header);
        end
      end
    end
  end

  // APB write of the magic word; lands on the access-phase edge
  task automatic write_magic(input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MAGIC_WORD, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_magic = v;
  endtask

  // Wait until every word is taken and every result is back, then let the
  // header replay settle before touching the register
  task automatic drain();
    @(negedge clk);
    while (rx_bytes_q.size() > 0 || in_valid || deframed_q.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_header(input logic [31:0] magic, input logic [31:0] len);
    for (int k = 0; k < 4; k++) rx_bytes_q.push_back(magic[8*k +: 8]);
    for (int k = 0; k < 4; k++) rx_bytes_q.push_back(len[8*k +: 8]);
  endtask

  // Good frame with random body words
  task automatic send_frame(input logic [31:0] len);
    send_header(cur_magic, len);
    for (int unsigned k = HDR_BYTES; k < len; k++)
      rx_bytes_q.push_back(8'($urandom));
  endtask

  // Random traffic: mostly good frames, some broken headers and noise
  task automatic random_traffic(input int nbytes);
    int          pick;
    logic [31:0] len;
    int          start;
    start = rx_bytes_q.size();
    while (rx_bytes_q.size() - start < nbytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(9, 40) : $urandom_range(9, 20);
        send_frame(len);
      end else if (pick < 82) begin
        send_header(cur_magic ^ (32'd1 << $urandom_range(31)), $urandom_range(9, 20));
      end else if (pick < 94) begin
        case ($urandom_range(2))
          0:       len = $urandom_range(0, 8);
          1:       len = 32'($urandom_range(61441, 65535));
          default: len = $urandom | 32'h0001_0000;
        endcase
        send_header(cur_magic, len);
      end else begin
        for (int k = 0; k < HDR_BYTES; k++) rx_bytes_q.push_back(8'($urandom));
      end
    end
  endtask

  // Stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset magic of zero, a zero-length header, then the shortest frame
    rx_bytes_q.push_back(8'h00);
    send_header(32'h0, 32'h0);
    rx_bytes_q.delete(0);
    send_frame(32'd9);
    rx_bytes_q[rx_bytes_q.size()-1] = 8'hFF;
    drain();

    // directed: all-ones magic, the length limits and near-miss magic words
    write_magic(32'hFFFF_FFFF);
    @(negedge clk);
    send_header(cur_magic, 32'd8);
    send_frame(32'd9);
    rx_bytes_q[rx_bytes_q.size()-1] = 8'h00;
    send_header(cur_magic, MAX_PACKET_BYTES + 32'd1);
    send_header(cur_magic, 32'hFFFF_FFFF);
    send_header(cur_magic, 32'h0001_0009);
    send_header(32'hFFFF_FFFE, 32'd10);
    send_header(32'h7FFF_FFFF, 32'd10);
    send_header(cur_magic, 32'd0);
    drain();

    // directed: short frame under a random magic, at full rate
    write_magic($urandom);
    @(negedge clk);
    send_frame(32'd10);
    drain();

    // random phases: free flow, slow sender, slow receiver, both
    write_magic(32'h0);
    @(negedge clk);
    random_traffic(10);
    drain();

    write_magic($urandom);
    @(negedge clk);
    src_idle_pct = 83;
    random_traffic(10);
    drain();

    write_magic($urandom);
    @(negedge clk);
    src_idle_pct = 0;
    sink_stall_pct = 83;
    random_traffic(10);
    drain();

    write_magic($urandom);
    @(negedge clk);
    src_idle_pct = 20;
    sink_stall_pct = 20;
    random_traffic(10);
    drain();

    if (mismatch_cnt == 0 && deframed_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
